### rtl/filtered_trace_ring_buffer_unit_defines.svh
`ifndef FILTERED_TRACE_RING_BUFFER_UNIT_DEFINES_SVH
`define FILTERED_TRACE_RING_BUFFER_UNIT_DEFINES_SVH

// Implication checked in the same cycle, outside reset.
`define FTRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle, outside reset.
`define FTRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ftrb_pkg.sv
package ftrb_pkg;

  // Fixed architectural limits.
  localparam int SUBSYSTEMS    = 5;
  localparam int MAX_ARGUMENTS = 4;
  localparam int MAX_RESULTS   = 64;
  localparam int ADDR_W        = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_THR_CORE     = 3'd0;
  localparam logic [2:0] REG_THR_MOTION   = 3'd1;
  localparam logic [2:0] REG_THR_COMMS    = 3'd2;
  localparam logic [2:0] REG_THR_HEATER   = 3'd3;
  localparam logic [2:0] REG_THR_TRIGGER  = 3'd4;
  localparam logic [2:0] REG_RING_SIZE    = 3'd5;
  localparam logic [2:0] REG_DRAIN_BUDGET = 3'd6;

  // Function codes of an input item.
  localparam logic FUNC_EMIT  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] event_id;
    logic [2:0]  subsystem;
    logic [7:0]  level;
    logic [7:0]  arg_count;
    logic [31:0] arg_zero;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [31:0] stamp;
    logic [15:0] event_code;
    logic [2:0]  sub_number;
    logic [7:0]  severity;
    logic [2:0]  valid_args;
    logic [31:0] out_arg_zero;
    logic [31:0] out_arg_one;
    logic [31:0] out_arg_two;
    logic [31:0] out_arg_three;
    logic [31:0] dropped_total;
    logic        last;
  } out_item_t;

  // Register file contents seen by the datapath.
  typedef struct packed {
    logic [SUBSYSTEMS-1:0][7:0] threshold;
    logic [8:0]                 ring_size;
    logic [6:0]                 drain_budget;
  } cfg_regs_t;

  // Write strobes of the registers that also touch the sequence state.
  typedef struct packed {
    logic size_wr;
    logic budget_wr;
  } cfg_evt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic emit_wr;
    logic evict;
    logic count;
    logic fetch;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drain_off;
    logic rem_zero;
    logic fetch_room;
    logic pipe_empty;
  } dp_status_t;

endpackage

### rtl/ftrb_regs.sv
module ftrb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ftrb_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output ftrb_pkg::cfg_regs_t            cfg,
  output ftrb_pkg::cfg_evt_t             cfg_evt
);
  import ftrb_pkg::*;

  logic                       wr_en;
  logic [2:0]                 idx;
  logic [SUBSYSTEMS-1:0][7:0] thr_r;
  logic [8:0]                 ring_size_r;
  logic [6:0]                 budget_r;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      ring_size_r <= '0;
      budget_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_THR_CORE:     thr_r[0]    <= pwdata[7:0];
        REG_THR_MOTION:   thr_r[1]    <= pwdata[7:0];
        REG_THR_COMMS:    thr_r[2]    <= pwdata[7:0];
        REG_THR_HEATER:   thr_r[3]    <= pwdata[7:0];
        REG_THR_TRIGGER:  thr_r[4]    <= pwdata[7:0];
        REG_RING_SIZE:    ring_size_r <= pwdata[8:0];
        REG_DRAIN_BUDGET: budget_r    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_THR_CORE:     prdata = {24'd0, thr_r[0]};
      REG_THR_MOTION:   prdata = {24'd0, thr_r[1]};
      REG_THR_COMMS:    prdata = {24'd0, thr_r[2]};
      REG_THR_HEATER:   prdata = {24'd0, thr_r[3]};
      REG_THR_TRIGGER:  prdata = {24'd0, thr_r[4]};
      REG_RING_SIZE:    prdata = {23'd0, ring_size_r};
      REG_DRAIN_BUDGET: prdata = {25'd0, budget_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.threshold    = thr_r;
  assign cfg.ring_size    = ring_size_r;
  assign cfg.drain_budget = budget_r;

  // Strobes let the datapath reset its sequence state in the same cycle.
  assign cfg_evt.size_wr   = wr_en && (idx == REG_RING_SIZE);
  assign cfg_evt.budget_wr = wr_en && (idx == REG_DRAIN_BUDGET);

endmodule

### rtl/ftrb_ctrl.sv
module ftrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  ftrb_pkg::dp_status_t   status,
  output ftrb_pkg::dp_cmd_t      cmd
);
  import ftrb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_COUNT,
    ST_STREAM
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  // Next state: a drain walks eviction, counting and streaming.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_DRAIN) && !status.drain_off) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT:  state_nxt = ST_COUNT;
      ST_COUNT:  state_nxt = ST_STREAM;
      ST_STREAM: begin
        if (status.rem_zero && status.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  // Commands to the datapath.
  assign cmd.emit_wr = accept && (in_func == FUNC_EMIT);
  assign cmd.evict   = (state_r == ST_EVICT);
  assign cmd.count   = (state_r == ST_COUNT);
  assign cmd.fetch   = (state_r == ST_STREAM) && !status.rem_zero && status.fetch_room;

endmodule

### rtl/ftrb_dp.sv
module ftrb_dp #(
  parameter int RING_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ftrb_pkg::cfg_regs_t   cfg,
  input  ftrb_pkg::cfg_evt_t    cfg_evt,
  input  ftrb_pkg::in_item_t    in_item,
  input  ftrb_pkg::dp_cmd_t     cmd,
  output ftrb_pkg::dp_status_t  status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ftrb_pkg::out_item_t   out_item
);
  import ftrb_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DW = $clog2(RING_DEPTH + 1);
  localparam int SW = (DW > 9) ? DW : 9;

  typedef struct packed {
    logic [15:0]                     event_id;
    logic [2:0]                      sub;
    logic [7:0]                      level;
    logic [2:0]                      argc;
    logic [31:0]                     stamp;
    logic [MAX_ARGUMENTS-1:0][31:0]  args;
  } rec_t;

  rec_t        mem [RING_DEPTH];
  rec_t        mem_q_r;
  rec_t        wr_rec;

  logic [31:0]   wseq_r, wseq_nxt;
  logic [31:0]   rseq_r, rseq_nxt;
  logic [31:0]   drop_r, drop_nxt;
  logic [31:0]   oldest_r;
  logic [AW-1:0] wslot_r, wslot_nxt;
  logic [AW-1:0] rslot_r, rslot_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic          q_valid_r, q_valid_nxt;
  logic [31:0]   q_seq_r;
  logic          q_last_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;

  logic [SW-1:0] used_size, last_slot;
  logic [6:0]    budget_eff;
  logic [7:0]    thr;
  logic          keep;
  logic          q_move;
  logic [32:0]   lag;
  logic [31:0]   avail;

  // Ring size in use and budget, both clipped to their limits.
  assign used_size  = (SW'(cfg.ring_size) > SW'(RING_DEPTH)) ? SW'(RING_DEPTH)
                                                             : SW'(cfg.ring_size);
  assign last_slot  = used_size - SW'(1);
  assign budget_eff = (cfg.drain_budget > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS)
                                                           : cfg.drain_budget;

  // Threshold of the item's subsystem.
  always_comb begin
    thr = '0;
    for (int i = 0; i < SUBSYSTEMS; i++) begin
      if (in_item.subsystem == 3'(i)) begin
        thr = cfg.threshold[i];
      end
    end
  end

  assign keep = (used_size != '0) && (32'(in_item.subsystem) < 32'(SUBSYSTEMS)) &&
                (in_item.level <= thr);

  // Record as stored, with the argument count clamped.
  always_comb begin
    wr_rec.event_id = in_item.event_id;
    wr_rec.sub      = in_item.subsystem;
    wr_rec.level    = in_item.level;
    wr_rec.argc     = (in_item.arg_count > 8'(MAX_ARGUMENTS)) ? 3'(MAX_ARGUMENTS)
                                                             : in_item.arg_count[2:0];
    wr_rec.stamp    = in_item.timestamp;
    wr_rec.args[0]  = in_item.arg_zero;
    wr_rec.args[1]  = in_item.arg_one;
    wr_rec.args[2]  = in_item.arg_two;
    wr_rec.args[3]  = in_item.arg_three;
  end

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] slot,
                                             input logic [SW-1:0] last);
    return (SW'(slot) == last) ? '0 : slot + AW'(1);
  endfunction

  // Distance from the read pointer to the oldest stored record.
  assign lag   = {1'b0, oldest_r} - {1'b0, rseq_r};
  assign avail = wseq_r - rseq_r;

  // Output pipeline: fetched record moves on when the output register frees up.
  assign q_move = q_valid_r && (!out_valid_r || out_ready);

  // Sequence state and pipeline control.
  always_comb begin
    wseq_nxt      = wseq_r;
    rseq_nxt      = rseq_r;
    drop_nxt      = drop_r;
    wslot_nxt     = wslot_r;
    rslot_nxt     = rslot_r;
    rem_nxt       = rem_r;
    if (cfg_evt.size_wr) begin
      wseq_nxt  = '0;
      rseq_nxt  = '0;
      drop_nxt  = '0;
      wslot_nxt = '0;
      rslot_nxt = '0;
    end else if (cfg_evt.budget_wr) begin
      rseq_nxt  = wseq_r;
      rslot_nxt = wslot_r;
    end else begin
      if (cmd.emit_wr && keep) begin
        wseq_nxt  = wseq_r + 32'd1;
        wslot_nxt = slot_inc(wslot_r, last_slot);
      end
      // Records overwritten since the last read count as dropped.
      if (cmd.evict && !lag[32] && (lag[31:0] != '0)) begin
        drop_nxt  = drop_r + lag[31:0];
        rseq_nxt  = oldest_r;
        rslot_nxt = wslot_r;
      end
      if (cmd.count) begin
        rem_nxt = (avail < 32'(budget_eff)) ? avail[6:0] : budget_eff;
      end
      if (cmd.fetch) begin
        rseq_nxt  = rseq_r + 32'd1;
        rslot_nxt = slot_inc(rslot_r, last_slot);
        rem_nxt   = rem_r - 7'd1;
      end
    end
  end

  always_comb begin
    if (cmd.fetch) begin
      q_valid_nxt = 1'b1;
    end else if (q_move) begin
      q_valid_nxt = 1'b0;
    end else begin
      q_valid_nxt = q_valid_r;
    end
    if (q_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wseq_r      <= '0;
      rseq_r      <= '0;
      drop_r      <= '0;
      wslot_r     <= '0;
      rslot_r     <= '0;
      rem_r       <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wseq_r      <= wseq_nxt;
      rseq_r      <= rseq_nxt;
      drop_r      <= drop_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      rem_r       <= rem_nxt;
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Oldest sequence still in the ring, registered from the write pointer.
  always_ff @(posedge clk) begin
    oldest_r <= (wseq_r > 32'(used_size)) ? (wseq_r - 32'(used_size)) : '0;
  end

  // Ring storage: one write port for emits, one registered read port for drains.
  always_ff @(posedge clk) begin
    if (cmd.emit_wr && keep && !cfg_evt.size_wr && !cfg_evt.budget_wr) begin
      mem[wslot_r] <= wr_rec;
    end
    if (cmd.fetch && !cfg_evt.size_wr && !cfg_evt.budget_wr) begin
      mem_q_r  <= mem[rslot_r];
      q_seq_r  <= rseq_r;
      q_last_r <= (rem_r == 7'd1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (q_move) begin
      out_item_r.seq_number    <= q_seq_r;
      out_item_r.stamp         <= mem_q_r.stamp;
      out_item_r.event_code    <= mem_q_r.event_id;
      out_item_r.sub_number    <= mem_q_r.sub;
      out_item_r.severity      <= mem_q_r.level;
      out_item_r.valid_args    <= mem_q_r.argc;
      out_item_r.out_arg_zero  <= mem_q_r.args[0];
      out_item_r.out_arg_one   <= mem_q_r.args[1];
      out_item_r.out_arg_two   <= mem_q_r.args[2];
      out_item_r.out_arg_three <= mem_q_r.args[3];
      out_item_r.dropped_total <= drop_r;
      out_item_r.last          <= q_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign status.drain_off  = (used_size == '0) || (budget_eff == '0);
  assign status.rem_zero   = (rem_r == '0);
  assign status.fetch_room = !q_valid_r || q_move;
  assign status.pipe_empty = !q_valid_r && !out_valid_r;

endmodule

### rtl/filtered_trace_ring_buffer_unit.sv
// Trace buffer with per-subsystem level filtering and an overwriting ring.
// Input channel (in_valid/in_ready/in_data): an emit transaction stores a
// record if its subsystem and level pass the filter; it gives no output and
// the next transaction can be taken in the following cycle.
// A drain transaction streams up to drain_budget stored records, oldest first,
// on the output channel (out_valid/out_ready/out_data), with last set on the
// final one. After acceptance, stale records are evicted and pending ones
// counted; each is then read from the ring into a register and moved on to
// the output register, one per cycle while out_ready stays high; a stalled
// receiver holds the current record and the ring read pauses behind it.
// in_ready is low until after the last record is taken. A drain with a zero
// budget or no ring configured is taken like an emit and leaves in_ready high.
// Configuration is an APB-style register port (cfg_*), written while idle.
// Writing ring_size clears the sequence and drop counters; writing
// drain_budget moves the read pointer past the newest record.
// Synchronous reset (rst_n low) clears configuration, state and counters; ring
// contents are not cleared and are never read before being written.
module filtered_trace_ring_buffer_unit #(
  parameter int RING_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ftrb_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ftrb_pkg::out_item_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ftrb_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import ftrb_pkg::*;

  cfg_regs_t  cfg;
  cfg_evt_t   cfg_evt;
  dp_cmd_t    cmd;
  dp_status_t status;

  ftrb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .cfg_evt (cfg_evt)
  );

  ftrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_data.func),
    .status   (status),
    .cmd      (cmd)
  );

  ftrb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_evt   (cfg_evt),
    .in_item   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

### rtl/ftrb_checker.sv
`include "filtered_trace_ring_buffer_unit_defines.svh"

module ftrb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ftrb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ftrb_pkg::out_item_t out_data
);
  import ftrb_pkg::*;

  // A stalled record stays put until it is taken.
  `FTRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "record changed while stalled")

  // No new transaction is taken while drain records are still pending.
  `FTRB_ASSERT_SAME(a_busy_no_accept, out_valid, !in_ready, "input taken during a drain")

  // An emit never produces a record.
  `FTRB_ASSERT_NEXT(a_emit_silent, in_valid && in_ready && (in_data.func == FUNC_EMIT), !out_valid, "emit produced a record")

  // Stored argument count is clamped and subsystem filtered.
  `FTRB_ASSERT_SAME(a_rec_ranges, out_valid, (out_data.valid_args <= 3'd4) && (out_data.sub_number <= 3'd4), "record field out of range")

endmodule

bind filtered_trace_ring_buffer_unit ftrb_checker u_ftrb_checker (.*);

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ftrb_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 200;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int PRINT_LIMIT = 40;
  // Index that no register occupies; writes there must have no effect.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  filtered_trace_ring_buffer_unit #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the registers and the trace ring.
  logic [7:0] level_limit [SUBSYSTEMS];
  logic [8:0] ring_setting;
  logic [6:0] budget_setting;
  logic [31:0] head_seq;
  logic [31:0] read_seq;
  logic [31:0] drop_total;
  out_item_t ring_image [RING_DEPTH];
  out_item_t expected_records [$];

  bit calm;
  bit hold_request;
  int mismatch_count;
  int records_checked;
  int emits_sent;
  int drains_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Each mismatch is counted; the first PRINT_LIMIT print one line each.
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want,
                               logic [31:0] seq);
    if (got !== want) begin
      report_mismatch($sformatf("record %0d field %s: got %h, expected %h",
                                seq, name, got, want));
    end
  endtask

  // Update the shadow registers the same way a register write does.
  function automatic void apply_register_write(logic [2:0] idx, logic [31:0] value);
    case (idx)
      REG_THR_CORE, REG_THR_MOTION, REG_THR_COMMS, REG_THR_HEATER,
      REG_THR_TRIGGER: begin
        level_limit[idx] = value[7:0];
      end
      REG_RING_SIZE: begin
        ring_setting = value[8:0];
        head_seq = '0;
        read_seq = '0;
        drop_total = '0;
      end
      REG_DRAIN_BUDGET: begin
        budget_setting = value[6:0];
        read_seq = head_seq;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      REG_THR_CORE, REG_THR_MOTION, REG_THR_COMMS, REG_THR_HEATER,
      REG_THR_TRIGGER: return {24'd0, level_limit[idx]};
      REG_RING_SIZE: return {23'd0, ring_setting};
      REG_DRAIN_BUDGET: return {25'd0, budget_setting};
      default: return '0;
    endcase
  endfunction

  // Store an accepted emit in the shadow ring, or queue a drain's records.
  function automatic void predict_records(in_item_t it);
    int unsigned used;
    int unsigned budget;
    int unsigned pending;
    int unsigned count;
    logic [31:0] oldest;
    out_item_t rec;
    used = (ring_setting > RING_DEPTH) ? RING_DEPTH : ring_setting;
    if (used == 0) return;
    if (it.func == FUNC_EMIT) begin
      if (it.subsystem >= SUBSYSTEMS) return;
      if (it.level > level_limit[it.subsystem]) return;
      rec = '0;
      rec.stamp = it.timestamp;
      rec.event_code = it.event_id;
      rec.sub_number = it.subsystem;
      rec.severity = it.level;
      rec.valid_args = (it.arg_count > MAX_ARGUMENTS) ? 3'(MAX_ARGUMENTS)
                                                      : it.arg_count[2:0];
      rec.out_arg_zero = it.arg_zero;
      rec.out_arg_one = it.arg_one;
      rec.out_arg_two = it.arg_two;
      rec.out_arg_three = it.arg_three;
      ring_image[head_seq % used] = rec;
      head_seq++;
      return;
    end
    budget = (budget_setting > MAX_RESULTS) ? MAX_RESULTS : budget_setting;
    if (budget == 0) return;
    // Records overwritten since the last read count as dropped.
    oldest = (head_seq > used) ? head_seq - used : 32'd0;
    if (read_seq < oldest) begin
      drop_total += oldest - read_seq;
      read_seq = oldest;
    end
    pending = head_seq - read_seq;
    count = (pending < budget) ? pending : budget;
    for (int k = 0; k < count; k++) begin
      rec = ring_image[read_seq % used];
      rec.seq_number = read_seq;
      rec.dropped_total = drop_total;
      rec.last = (k == count - 1);
      expected_records.push_back(rec);
      read_seq++;
    end
  endfunction

  // Register write, then a read back unless the index is REG_UNUSED.
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    logic [31:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    apply_register_write(idx, value);
    if (idx == REG_UNUSED) begin
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      @(posedge clk);
      return;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (readback !== register_value(idx)) begin
      report_mismatch($sformatf("register %0d read back %h, expected %h",
                                idx, readback, register_value(idx)));
    end
  endtask

  // Offer one transaction, with an occasional idle burst ahead of it.
  task automatic push_trace_item(in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_records(it);
    if (it.func == FUNC_EMIT) emits_sent++;
    else drains_sent++;
  endtask

  // Wait until every expected record has come and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_emit(logic [2:0] sub, logic [7:0] lvl,
                                           logic [7:0] argc);
    in_item_t it;
    it.func = FUNC_EMIT;
    it.event_id = 16'($urandom);
    it.subsystem = sub;
    it.level = lvl;
    it.arg_count = argc;
    it.arg_zero = $urandom;
    it.arg_one = $urandom;
    it.arg_two = $urandom;
    it.arg_three = $urandom;
    it.timestamp = $urandom;
    return it;
  endfunction

  // A drain carries random junk in the fields it does not use.
  function automatic in_item_t drain_item();
    in_item_t it;
    it = random_emit(3'($urandom), 8'($urandom), 8'($urandom));
    it.func = FUNC_DRAIN;
    return it;
  endfunction

  // An emit that passes the level filter under the current limits.
  function automatic in_item_t good_emit();
    logic [2:0] sub;
    logic [7:0] argc;
    sub = 3'($urandom_range(0, SUBSYSTEMS - 1));
    argc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    return random_emit(sub, 8'($urandom_range(0, level_limit[sub])), argc);
  endfunction

  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return drain_item();
    if (pick < 85) return good_emit();
    return random_emit(3'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [31:0] random_limit();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Ready side: random stall bursts, plus one long hold on request.
  initial begin : receiver
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each record taken from the block with the oldest expected one.
  always @(posedge clk) begin : record_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record seq %0d", out_data.seq_number));
      end else begin
        want = expected_records.pop_front();
        compare_field("seq_number", out_data.seq_number, want.seq_number,
                      want.seq_number);
        compare_field("stamp", out_data.stamp, want.stamp, want.seq_number);
        compare_field("event_code", out_data.event_code, want.event_code,
                      want.seq_number);
        compare_field("sub_number", out_data.sub_number, want.sub_number,
                      want.seq_number);
        compare_field("severity", out_data.severity, want.severity, want.seq_number);
        compare_field("valid_args", out_data.valid_args, want.valid_args,
                      want.seq_number);
        compare_field("out_arg_zero", out_data.out_arg_zero, want.out_arg_zero,
                      want.seq_number);
        compare_field("out_arg_one", out_data.out_arg_one, want.out_arg_one,
                      want.seq_number);
        compare_field("out_arg_two", out_data.out_arg_two, want.out_arg_two,
                      want.seq_number);
        compare_field("out_arg_three", out_data.out_arg_three, want.out_arg_three,
                      want.seq_number);
        compare_field("dropped_total", out_data.dropped_total, want.dropped_total,
                      want.seq_number);
        compare_field("last", out_data.last, want.last, want.seq_number);
        records_checked++;
      end
    end
  end

  // With no ring configured, emits and drains do nothing.
  task automatic test_unconfigured_ring();
    settle();
    write_register(REG_DRAIN_BUDGET, 32'd5);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    push_trace_item(random_emit(3'd0, 8'd0, 8'd1));
    push_trace_item(drain_item());
    settle();
  endtask

  // Per-subsystem level limits, field extremes and argument clamping.
  task automatic test_level_filter();
    in_item_t it;
    settle();
    write_register(REG_THR_CORE, 32'd255);
    write_register(REG_THR_MOTION, 32'd0);
    write_register(REG_THR_COMMS, 32'd128);
    write_register(REG_THR_HEATER, 32'd1);
    write_register(REG_THR_TRIGGER, 32'd200);
    write_register(REG_RING_SIZE, 32'd8);
    write_register(REG_DRAIN_BUDGET, 32'd64);
    // All ones in every field that is stored.
    it = random_emit(3'd0, 8'd255, 8'd255);
    it.event_id = '1;
    it.arg_zero = '1;
    it.arg_one = '1;
    it.arg_two = '1;
    it.arg_three = '1;
    it.timestamp = '1;
    push_trace_item(it);
    // All zeros.
    it = random_emit(3'd1, 8'd0, 8'd0);
    it.event_id = '0;
    it.arg_zero = '0;
    it.arg_one = '0;
    it.arg_two = '0;
    it.arg_three = '0;
    it.timestamp = '0;
    push_trace_item(it);
    push_trace_item(random_emit(3'd1, 8'd1, 8'd2));
    push_trace_item(random_emit(3'd2, 8'd128, 8'd3));
    push_trace_item(random_emit(3'd2, 8'd129, 8'd4));
    // Subsystems past the last one are always dropped.
    push_trace_item(random_emit(3'd5, 8'd0, 8'd0));
    push_trace_item(random_emit(3'd7, 8'd0, 8'd0));
    push_trace_item(random_emit(3'd4, 8'd200, 8'd4));
    push_trace_item(random_emit(3'd3, 8'd1, 8'd5));
    push_trace_item(drain_item());
    settle();
  endtask

  // Overwrite in a small ring, drop counting, budget write and zero budget.
  task automatic test_overwrite_and_drop();
    settle();
    write_register(REG_RING_SIZE, 32'd4);
    write_register(REG_DRAIN_BUDGET, 32'd2);
    repeat (3) push_trace_item(good_emit());
    settle();
    // The budget write skips the three records already stored.
    write_register(REG_DRAIN_BUDGET, 32'd2);
    repeat (6) push_trace_item(good_emit());
    push_trace_item(drain_item());
    push_trace_item(drain_item());
    settle();
    write_register(REG_DRAIN_BUDGET, 32'd0);
    push_trace_item(good_emit());
    push_trace_item(drain_item());
    settle();
  endtask

  // One phase of random traffic under one register setting.
  task automatic run_random_phase(int count, logic [8:0] ring, logic [6:0] budget);
    settle();
    write_register(REG_THR_CORE, random_limit());
    write_register(REG_THR_MOTION, random_limit());
    write_register(REG_THR_COMMS, random_limit());
    write_register(REG_THR_HEATER, random_limit());
    write_register(REG_THR_TRIGGER, random_limit());
    write_register(REG_RING_SIZE, {23'd0, ring});
    write_register(REG_DRAIN_BUDGET, {25'd0, budget});
    repeat (count) push_trace_item(random_item());
    settle();
  endtask

  task automatic test_random_settings();
    run_random_phase(32, 9'd1, 7'd1);
    run_random_phase(32, 9'($urandom_range(2, 12)), 7'($urandom_range(1, 8)));
    // Sizes past the limits are used as the limits.
    run_random_phase(32, 9'd511, 7'd127);
    run_random_phase(32, 9'd256, 7'd64);
  endtask

  // The receiver stalls for a long time during a drain, and emits wait behind it.
  task automatic test_receiver_backpressure();
    settle();
    write_register(REG_RING_SIZE, 32'd16);
    write_register(REG_DRAIN_BUDGET, 32'd64);
    repeat (20) push_trace_item(good_emit());
    hold_request = 1'b1;
    push_trace_item(drain_item());
    repeat (6) push_trace_item(good_emit());
    push_trace_item(drain_item());
    settle();
  endtask

  task automatic test_without_idling();
    calm = 1'b1;
    run_random_phase(30, 9'($urandom_range(1, 24)), 7'($urandom_range(1, 64)));
  endtask

  initial begin : main
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    // Shadow state after reset.
    for (int s = 0; s < SUBSYSTEMS; s++) level_limit[s] = '0;
    ring_setting = '0;
    budget_setting = '0;
    head_seq = '0;
    read_seq = '0;
    drop_total = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_unconfigured_ring();
    test_level_filter();
    test_overwrite_and_drop();
    test_random_settings();
    test_receiver_backpressure();
    test_without_idling();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d emit and %0d drain transactions; checked %0d records.",
             emits_sent, drains_sent, records_checked);
    $display("Rings from one entry to oversized, zero to oversized budgets, long stall.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d records still expected.", expected_records.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ftrb_pkg.sv
rtl/ftrb_regs.sv
rtl/ftrb_ctrl.sv
rtl/ftrb_dp.sv
rtl/filtered_trace_ring_buffer_unit.sv
rtl/ftrb_checker.sv
test/testbench.sv
